// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the terminal writer (used by the top-level file).
// Include with the bare file name; the block's clock and reset are clk_i / rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules clocked by clk_i with reset rst_ni.
`define ASSERT_CHK(lbl, prop, msg) \
  `ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- src/tmtw_pkg.sv -----
// Package for the text mode terminal writer: word types, field widths,
// character and fill constants. No dependencies.
`timescale 1ns / 1ps

package tmtw_pkg;

  localparam int ScreenColumnsDef = 80;
  localparam int ScreenRowsDef    = 25;

  // Fixed port field widths
  localparam int OpW          = 2;
  localparam int ByteW        = 8;
  localparam int IndexFieldW  = 11;
  localparam int ColumnFieldW = 7;
  localparam int RowFieldW    = 5;
  localparam int CellW        = 16;

  localparam int TabStep = 8;

  localparam logic [CellW-1:0] BlankScroll = 16'h0720;
  localparam logic [CellW-1:0] BlankClear  = 16'h0700;
  localparam logic [ByteW-1:0] DefaultAttr = 8'h07;

  localparam logic [ByteW-1:0] ChBackspace = 8'h08;
  localparam logic [ByteW-1:0] ChTab       = 8'h09;
  localparam logic [ByteW-1:0] ChNewline   = 8'h0A;
  localparam logic [ByteW-1:0] ChReturn    = 8'h0D;
  localparam logic [ByteW-1:0] ChFirstPrint = 8'h20;

  typedef enum logic [OpW-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]         operation;
    logic [ByteW-1:0]       char_code;
    logic [ByteW-1:0]       attribute;
    logic [IndexFieldW-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [ColumnFieldW-1:0] cursor_column;
    logic [RowFieldW-1:0]    cursor_row;
    logic [IndexFieldW-1:0]  cursor_index;
    logic                    cell_written;
    logic [IndexFieldW-1:0]  written_index;
    logic [CellW-1:0]        written_cell;
    logic                    scrolled;
    logic [CellW-1:0]        read_cell;
  } out_word_t;

endpackage

// ----- src/tmtw_ifs.sv -----
// Valid/ready channel interfaces for the terminal writer input and result words.
// Depends on tmtw_pkg.
`timescale 1ns / 1ps

interface tmtw_in_if;
  import tmtw_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tmtw_out_if;
  import tmtw_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tmtw_cell_ram.sv -----
// Screen cell memory: one write port, one read port with registered data.
// Depends on tmtw_pkg.
`timescale 1ns / 1ps

module tmtw_cell_ram #(
  parameter int Depth = 2000,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [tmtw_pkg::CellW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [tmtw_pkg::CellW-1:0] rdata_o
);
  import tmtw_pkg::*;

  logic [CellW-1:0] mem_q [Depth];
  logic [CellW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/text_mode_terminal_writer_top.sv -----
// Clear and scroll rewrite the screen one cell per cycle through the single write port.
// Throughput: one word in flight; a new word is taken once the previous one is done.
// Reset: asynchronous, active low; cursor homes and a clearing pass writes 0x0700
// to every cell, with in_i.ready low meanwhile.
// Depends on tmtw_pkg, tmtw_ifs, tmtw_cell_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_mode_terminal_writer_top #(
  parameter int ScreenColumns = tmtw_pkg::ScreenColumnsDef,
  parameter int ScreenRows    = tmtw_pkg::ScreenRowsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmtw_in_if.sink    in_i,
  tmtw_out_if.source out_o
);
  import tmtw_pkg::*;

  localparam int CellCount = ScreenColumns * ScreenRows;
  localparam int AddrW     = $clog2(CellCount);
  localparam int IdxSumW   = AddrW + 1;
  localparam int PtrW      = $clog2(CellCount + 1);
  localparam int ColW      = $clog2(ScreenColumns + TabStep);
  localparam int RowW      = $clog2(ScreenRows + 1);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_COPY = 6'b000100,
    S_FILL = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic             written;
    logic [AddrW-1:0] widx;
    logic [CellW-1:0] wcell;
    logic             scrolled;
    logic [CellW-1:0] rcell;
  } result_t;

  state_e           state_q, state_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] idx_q, idx_d;
  result_t          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  out_word_t        out_data_q, out_data_d;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [CellW-1:0] mem_wdata, mem_rdata;

  logic in_acc;

  // Put cursor arithmetic
  logic [ByteW-1:0]   attr_eff;
  logic [ColW-1:0]    col_mid, col_new, col_tab;
  logic [RowW-1:0]    row_mid;
  logic               row_inc, printable, wrap, scroll;
  logic [IdxSumW-1:0] idx_sum;
  logic               rd_in_range;

  assign in_acc = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign attr_eff  = (in_i.data.attribute == '0) ? DefaultAttr : in_i.data.attribute;
  assign printable = (in_i.data.char_code >= ChFirstPrint);
  assign col_tab   = (col_q + ColW'(TabStep)) & ~ColW'(TabStep - 1);

  always_comb begin
    col_mid = col_q;
    row_inc = 1'b0;
    priority if (in_i.data.char_code == ChBackspace) begin
      col_mid = (col_q == '0) ? col_q : col_q - 1'b1;
    end else if (in_i.data.char_code == ChTab) begin
      col_mid = col_tab;
    end else if (in_i.data.char_code == ChReturn) begin
      col_mid = '0;
    end else if (in_i.data.char_code == ChNewline) begin
      col_mid = '0;
      row_inc = 1'b1;
    end else if (printable) begin
      col_mid = col_q + 1'b1;
    end else begin
      col_mid = col_q;
    end
  end

  assign wrap    = (col_mid >= ColW'(ScreenColumns));
  assign col_new = wrap ? '0 : col_mid;
  assign row_mid = row_q + RowW'(row_inc || wrap);
  assign scroll  = (row_mid == RowW'(ScreenRows));
  // index moves with the cursor: back to row start, then forward
  assign idx_sum = IdxSumW'(idx_q) - IdxSumW'(col_q)
                 + ((row_inc || wrap) ? IdxSumW'(ScreenColumns) : IdxSumW'(col_new));
  assign rd_in_range = (int'(in_i.data.read_index) < CellCount);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    col_d       = col_q;
    row_d       = row_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = BlankClear;
    mem_raddr   = AddrW'(in_i.data.read_index);

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(ptr_q);
        mem_wdata = BlankClear;
        if (ptr_q == PtrW'(CellCount - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          ptr_d   = '0;
          state_d = S_DONE;
          unique case (in_i.data.operation)
            OP_PUT: begin
              if (printable) begin
                mem_we        = 1'b1;
                mem_waddr     = idx_q;
                mem_wdata     = {attr_eff, in_i.data.char_code};
                res_d.written = 1'b1;
                res_d.widx    = idx_q;
                res_d.wcell   = {attr_eff, in_i.data.char_code};
              end
              col_d = col_new;
              if (scroll) begin
                row_d          = RowW'(ScreenRows - 1);
                idx_d          = AddrW'(CellCount - ScreenColumns);
                res_d.scrolled = 1'b1;
                state_d        = S_COPY;
              end else begin
                row_d = row_mid;
                idx_d = AddrW'(idx_sum);
              end
            end
            OP_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              idx_d   = '0;
              state_d = S_FILL;
            end
            OP_READ: begin
              if (rd_in_range) begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_COPY: begin
        // read one row ahead, write the word read last cycle one row up
        mem_raddr = AddrW'(ptr_q + PtrW'(ScreenColumns));
        mem_we    = (ptr_q != '0);
        mem_waddr = AddrW'(ptr_q - 1'b1);
        mem_wdata = mem_rdata;
        if (ptr_q == PtrW'(CellCount - ScreenColumns)) begin
          state_d = S_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(ptr_q);
        mem_wdata = res_q.scrolled ? BlankScroll : BlankClear;
        if (ptr_q == PtrW'(CellCount - 1)) begin
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_READ: begin
        res_d.rcell = mem_rdata;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d              = 1'b1;
          out_data_d.cursor_column = ColumnFieldW'(col_q);
          out_data_d.cursor_row    = RowFieldW'(row_q);
          out_data_d.cursor_index  = IndexFieldW'(idx_q);
          out_data_d.cell_written  = res_q.written;
          out_data_d.written_index = IndexFieldW'(res_q.widx);
          out_data_d.written_cell  = res_q.wcell;
          out_data_d.scrolled      = res_q.scrolled;
          out_data_d.read_cell     = res_q.rcell;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
        ptr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      col_q       <= col_d;
      row_q       <= row_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  tmtw_cell_ram #(
    .Depth (CellCount)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  `ASSERT_CHK(a_cursor_in_bounds, (col_q < ColW'(ScreenColumns)) && (row_q < RowW'(ScreenRows)), "cursor out of screen")
  `ASSERT_CHK(a_index_tracks_cursor, IdxSumW'(idx_q) == IdxSumW'(row_q) * IdxSumW'(ScreenColumns) + IdxSumW'(col_q), "cursor index out of step")
  `ASSERT_CHK(a_write_in_range, mem_we |-> (int'(mem_waddr) < CellCount), "cell write beyond screen")
  `ASSERT_CHK(a_copy_no_overlap, (state_q == S_COPY && mem_we) |-> (mem_waddr != mem_raddr), "scroll copy hits its own read")
  `ASSERT_CHK(a_clear_homes, (in_acc && in_i.data.operation == OP_CLEAR) |=> (idx_q == '0) && (state_q == S_FILL), "clear did not home cursor")

endmodule
